// ===== hw/rtl/cvp_pkg.sv =====
// Shared constants and types for the cosine vignette pipeline.
package cvp_pkg;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int RAD_W   = 20;
  localparam int Q16_W   = 32;
  localparam int PH_W    = 16;
  localparam int FRAC_W  = 14;
  localparam int U2_W    = 31;
  localparam int CFG_A_W = 3;

  localparam logic [U2_W-1:0] COS_A   = 31'd1324675879;
  localparam logic [U2_W-1:0] COS_B   = 31'd272375560;
  localparam logic [U2_W-1:0] COS_C   = 31'd22401992;
  localparam logic [U2_W-1:0] COS_D   = 31'd987048;
  localparam logic [U2_W-1:0] Q30_ONE = 31'd1073741824;

  // Horner coefficients in the order the cells apply them
  localparam logic [U2_W-1:0] POLY_COEF [4] = '{COS_C, COS_B, COS_A, Q30_ONE};

  typedef enum logic [CFG_A_W-1:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_FALLOFF_RADIUS = 3'd2,
    CFG_OFFSET_LEVEL   = 3'd3,
    CFG_PEAK_INTENSITY = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic            vld;
    logic            neg;
    logic [U2_W-1:0] u2;
  } poly_ctl_t;

endpackage

// ===== hw/rtl/cvp_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root.
module cvp_sqrt_cell #(
  parameter int VW  = 42,
  parameter int RW  = 21,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [VW-1:0] v_i,
  input  logic [RW-1:0] root_i,
  input  logic [RW+1:0] rem_i,
  output logic          vld_o,
  output logic [VW-1:0] v_o,
  output logic [RW-1:0] root_o,
  output logic [RW+1:0] rem_o
);
  logic          vld_r;
  logic [VW-1:0] v_r;
  logic [RW-1:0] root_r, root_nxt;
  logic [RW+1:0] rem_r, rem_nxt;
  logic [RW+1:0] rem_sh, trial;
  logic          ge;

  // remainder stays below twice the partial root, so its top bits are zero here
  always_comb begin
    rem_sh   = {rem_i[RW-1:0], v_i[2*IDX+1 -: 2]};
    trial    = {root_i, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[RW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_i;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign v_o    = v_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;
endmodule

// ===== hw/rtl/cvp_div_cell.sv =====
// One quotient-bit cell of the pipelined phase divider.
module cvp_div_cell #(
  parameter int NW  = 35,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [cvp_pkg::RAD_W-1:0]   rad,
  input  logic                        vld_i,
  input  logic [NW-1:0]               n_i,
  input  logic [cvp_pkg::RAD_W-1:0]   rem_i,
  input  logic [cvp_pkg::PH_W-1:0]    q_i,
  output logic                        vld_o,
  output logic [NW-1:0]               n_o,
  output logic [cvp_pkg::RAD_W-1:0]   rem_o,
  output logic [cvp_pkg::PH_W-1:0]    q_o
);
  import cvp_pkg::*;

  logic             vld_r;
  logic [NW-1:0]    n_r;
  logic [RAD_W-1:0] rem_r, rem_nxt;
  logic [PH_W-1:0]  q_r, q_nxt;
  logic [RAD_W:0]   rem_sh, diff;
  logic             ge;

  // only the low quotient bits are kept: the phase wraps every full turn
  always_comb begin
    rem_sh  = {rem_i, n_i[IDX]};
    diff    = rem_sh - {1'b0, rad};
    ge      = (rem_sh >= {1'b0, rad});
    rem_nxt = ge ? diff[RAD_W-1:0] : rem_sh[RAD_W-1:0];
    q_nxt   = {q_i[PH_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_i;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign vld_o = vld_r;
  assign n_o   = n_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
endmodule

// ===== hw/rtl/cvp_poly_cell.sv =====
// One Horner step of the quarter-cosine polynomial: multiply, then subtract.
module cvp_poly_cell #(
  parameter logic [30:0] COEF = 31'd0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  cvp_pkg::poly_ctl_t         ctl_i,
  input  logic [cvp_pkg::U2_W-1:0]   s_i,
  output cvp_pkg::poly_ctl_t         ctl_o,
  output logic [cvp_pkg::U2_W-1:0]   s_o
);
  import cvp_pkg::*;

  logic              vld_a_r, vld_b_r;
  logic              neg_a_r, neg_b_r;
  logic [U2_W-1:0]   u2_a_r, u2_b_r;
  logic [2*U2_W-1:0] prod_r;
  logic [31:0]       sh;
  logic [U2_W-1:0]   s_r, s_nxt;

  // subtraction floors at zero
  always_comb begin
    sh    = prod_r[61:30];
    s_nxt = (sh > {1'b0, COEF}) ? '0 : U2_W'({1'b0, COEF} - sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= ctl_i.vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r <= ctl_i.neg;
      u2_a_r  <= ctl_i.u2;
      prod_r  <= s_i * ctl_i.u2;
      neg_b_r <= neg_a_r;
      u2_b_r  <= u2_a_r;
      s_r     <= s_nxt;
    end
  end

  assign ctl_o = '{vld: vld_b_r, neg: neg_b_r, u2: u2_b_r};
  assign s_o   = s_r;
endmodule

// ===== hw/rtl/cosine_vignette_pixel.sv =====
// Cosine vignette mask: pixel coordinate in, Q16.16 vignette value out.
// The block takes one pixel per clock while in_stall is low and returns one value per pixel, in order.
// RQW is the root width (one cell per root bit of the square root) and NW = RQW + 14
// is the dividend width (one cell per quotient bit of the phase divider); the
// cosine takes four Horner cells of two stages each. in_stall rises only when a
// result is held in the output skid register while the output is stalled; the
// whole chain then freezes. Configuration writes must be made only after the
// block has drained, so that they apply to items accepted after that; the block
// itself does not enforce this.
module cosine_vignette_pixel #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cvp_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [cvp_pkg::Q16_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cvp_pkg::COORD_W-1:0]   in_x_pos,
  input  logic [cvp_pkg::COORD_W-1:0]   in_y_pos,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [cvp_pkg::Q16_W-1:0] out_vignette_value
);
  import cvp_pkg::*;

  localparam int DW   = ($clog2(MAX_DIM) + 1 > DIM_W) ? $clog2(MAX_DIM) + 1 : DIM_W;
  localparam int MW   = (DW - 1 > COORD_W) ? DW - 1 : COORD_W;
  localparam int D2W  = 2 * MW + 1;
  localparam int RQW  = (D2W + 16 + 1) / 2;
  localparam int VW   = 2 * RQW;
  localparam int NW   = RQW + FRAC_W;
  localparam logic [DW-1:0] MAX_DIM_V = DW'(MAX_DIM);

  // configuration
  logic [DIM_W-1:0]        width_r, height_r;
  logic [RAD_W-1:0]        radius_r;
  logic signed [Q16_W-1:0] offset_r, peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      radius_r <= RAD_W'(256);
      offset_r <= '0;
      peak_r   <= Q16_W'(65536);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH:    width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT:   height_r <= cfg_wdata[DIM_W-1:0];
        CFG_FALLOFF_RADIUS: radius_r <= cfg_wdata[RAD_W-1:0];
        CFG_OFFSET_LEVEL:   offset_r <= cfg_wdata;
        CFG_PEAK_INTENSITY: peak_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [DW-1:0]    wid_c, hgt_c;
  logic [DW-2:0]    cx, cy;
  logic [RAD_W-1:0] rad;

  always_comb begin
    wid_c = (DW'(width_r) > MAX_DIM_V) ? MAX_DIM_V : DW'(width_r);
    hgt_c = (DW'(height_r) > MAX_DIM_V) ? MAX_DIM_V : DW'(height_r);
    cx    = wid_c[DW-1:1];
    cy    = hgt_c[DW-1:1];
    rad   = (radius_r == '0) ? RAD_W'(1) : radius_r;
  end

  // output register plus skid stage; the chain advances while the skid is empty
  logic                    pipe_en;
  logic                    skid_v_r;
  logic signed [Q16_W-1:0] skid_d_r;
  logic                    out_v_r;
  logic signed [Q16_W-1:0] out_d_r;

  assign pipe_en  = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage: offsets from centre
  logic                 s0_v_r;
  logic signed [MW:0]   dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (pipe_en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dx_r <= $signed({1'b0, MW'(in_x_pos)}) - $signed({1'b0, MW'(cx)});
      dy_r <= $signed({1'b0, MW'(in_y_pos)}) - $signed({1'b0, MW'(cy)});
    end
  end

  // stage: squared distance
  logic                   s1_v_r;
  logic [D2W-1:0]         d2_r;
  logic signed [2*MW+1:0] sqx, sqy;

  always_comb begin
    sqx = dx_r * dx_r;
    sqy = dy_r * dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d2_r <= D2W'(sqx[2*MW-1:0]) + D2W'(sqy[2*MW-1:0]);
    end
  end

  // square root chain, one root bit per cell
  logic          sq_v    [RQW+1];
  logic [VW-1:0] sq_d    [RQW+1];
  logic [RQW-1:0] sq_root [RQW+1];
  logic [RQW+1:0] sq_rem  [RQW+1];

  assign sq_v[0]    = s1_v_r;
  assign sq_d[0]    = VW'({d2_r, 16'b0});
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  for (genvar k = 0; k < RQW; k++) begin : g_sqrt
    cvp_sqrt_cell #(.VW(VW), .RW(RQW), .IDX(RQW - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (pipe_en),
      .vld_i  (sq_v[k]),
      .v_i    (sq_d[k]),
      .root_i (sq_root[k]),
      .rem_i  (sq_rem[k]),
      .vld_o  (sq_v[k+1]),
      .v_o    (sq_d[k+1]),
      .root_o (sq_root[k+1]),
      .rem_o  (sq_rem[k+1])
    );
  end

  // phase divider chain, one quotient bit per cell
  logic             dv_v   [NW+1];
  logic [NW-1:0]    dv_n   [NW+1];
  logic [RAD_W-1:0] dv_rem [NW+1];
  logic [PH_W-1:0]  dv_q   [NW+1];

  assign dv_v[0]   = sq_v[RQW];
  assign dv_n[0]   = {sq_root[RQW], FRAC_W'(0)};
  assign dv_rem[0] = '0;
  assign dv_q[0]   = '0;

  for (genvar k = 0; k < NW; k++) begin : g_div
    cvp_div_cell #(.NW(NW), .IDX(NW - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .rad   (rad),
      .vld_i (dv_v[k]),
      .n_i   (dv_n[k]),
      .rem_i (dv_rem[k]),
      .q_i   (dv_q[k]),
      .vld_o (dv_v[k+1]),
      .n_o   (dv_n[k+1]),
      .rem_o (dv_rem[k+1]),
      .q_o   (dv_q[k+1])
    );
  end

  // stage: fold phase into a quarter turn
  logic              fd_v_r, fd_neg_r;
  logic [FRAC_W:0]   fd_t_r;
  logic [1:0]        quad;
  logic [FRAC_W-1:0] frac;

  always_comb begin
    quad = dv_q[NW][PH_W-1 -: 2];
    frac = dv_q[NW][FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_v_r <= 1'b0;
    end else if (pipe_en) begin
      fd_v_r <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fd_neg_r <= quad[1] ^ quad[0];
      fd_t_r   <= quad[0] ? ((FRAC_W+1)'(1) << FRAC_W) - {1'b0, frac} : {1'b0, frac};
    end
  end

  // stage: u2 = 4*t*t, (t/16384)^2 in Q30
  poly_ctl_t           pc [5];
  logic [U2_W-1:0]     ps [5];
  logic [2*FRAC_W+1:0] tsq;
  logic                pc0_v_r, pc0_neg_r;
  logic [U2_W-1:0]     pc0_u2_r;

  assign tsq = fd_t_r * fd_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc0_v_r <= 1'b0;
    end else if (pipe_en) begin
      pc0_v_r <= fd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pc0_neg_r <= fd_neg_r;
      pc0_u2_r  <= U2_W'({tsq, 2'b00});
    end
  end

  assign pc[0] = '{vld: pc0_v_r, neg: pc0_neg_r, u2: pc0_u2_r};
  assign ps[0] = COS_D;

  for (genvar k = 0; k < 4; k++) begin : g_poly
    cvp_poly_cell #(.COEF(POLY_COEF[k])) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .ctl_i (pc[k]),
      .s_i   (ps[k]),
      .ctl_o (pc[k+1]),
      .s_o   (ps[k+1])
    );
  end

  // stage: round to Q16, clamp, apply quadrant sign
  logic               rd_v_r;
  logic signed [17:0] cv_r;
  logic [U2_W:0]      rsum;
  logic [16:0]        rq16;

  always_comb begin
    rsum = {1'b0, ps[4]} + (U2_W+1)'(8192);
    rq16 = (rsum[U2_W:FRAC_W] > (U2_W+1-FRAC_W)'(65536)) ? 17'd65536
                                                          : rsum[FRAC_W+16:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (pipe_en) begin
      rd_v_r <= pc[4].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      cv_r <= pc[4].neg ? -$signed({1'b0, rq16}) : $signed({1'b0, rq16});
    end
  end

  // stage: scale by intensity
  logic               ml_v_r;
  logic signed [49:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ml_v_r <= 1'b0;
    end else if (pipe_en) begin
      ml_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      prod_r <= peak_r * cv_r;
    end
  end

  // round half up to Q16.16, add offset, saturate
  logic signed [50:0]      pr_rnd;
  logic signed [35:0]      vsum;
  logic signed [Q16_W-1:0] res;

  always_comb begin
    pr_rnd = 51'(prod_r) + 51'sd32768;
    vsum   = 36'($signed(pr_rnd[50:16])) + 36'(offset_r);
    if (vsum > 36'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (vsum < -36'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = vsum[Q16_W-1:0];
    end
  end

  logic pipe_out_v;
  assign pipe_out_v = pipe_en && ml_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r  <= skid_v_r || pipe_out_v;
      skid_v_r <= 1'b0;
    end else if (pipe_out_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_d_r <= skid_v_r ? skid_d_r : res;
    end else if (pipe_out_v) begin
      skid_d_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_vignette_value = out_d_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds an item while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall))
    else $error("skid filled without a stalled output");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (!pipe_en && ml_v_r) |=> ml_v_r)
    else $error("frozen chain lost its last item");

endmodule
